/* src/mhpq_pkg.sv */
// shared types and constants for the min-heap priority queue
package mhpq_pkg;

  localparam int unsigned DEPTH = 256;
  localparam int unsigned AW    = $clog2(DEPTH + 1);  // address of slots 1..DEPTH
  localparam int unsigned CW    = $clog2(DEPTH + 1);  // count width

  typedef enum logic [1:0] {
    KIND_INSERT  = 2'd0,
    KIND_EXTRACT = 2'd1,
    KIND_FIND    = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic [15:0] vertex;
    logic [31:0] cost;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,      // read parent
    S_UP_CMP,     // compare carried entry against parent
    S_DN_RD_L,    // read left child
    S_DN_RD_R,    // read right child, latch left
    S_DN_CMP,     // latch right, decide
    S_FIND_RD,
    S_FIND_CMP,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // latch the accepted item
    logic ins_init;    // count++, pos = count
    logic ext_init;    // read root/last setup
    logic rd_parent;
    logic up_move;     // write parent at pos, pos = parent
    logic up_place;    // write carried entry at pos
    logic rd_left;
    logic rd_right;
    logic latch_left;
    logic dn_move;     // write best child at pos, pos = best
    logic dn_place;
    logic find_init;
    logic rd_find;
    logic find_next;
    logic find_hit;
    logic set_full;
    logic set_empty;
    logic set_nf;
    logic done;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  is_full;
    logic  is_zero;
    logic  at_root;
    logic  up_less;      // carried entry costs less than parent
    logic  has_left;
    logic  has_right;
    logic  dn_swap;      // some child costs less than carried entry
    logic  find_match;
    logic  find_last;
  } sts_t;

endpackage

/* src/min_heap_priority_queue.sv */
// top level of the min-heap priority queue
// binary min-heap of {vertex, cost} entries held in one 256-entry memory with
// a registered read port. pulse start while busy is low to issue one
// operation; exactly one result appears later for one cycle with out_valid
// high and must be taken then, the receiver cannot stall. insert climbs from
// the new last slot, reading and comparing the parent at each level; extract
// moves the last entry to the root and descends, reading the left child, then
// the right, then comparing; find scans the stored entries in slot order from
// the root. insert when full, extract or find on an empty heap and the unused
// kind answer straight from the dispatch state. busy falls the cycle after the
// result. the user must write capacity via cfg_we only while the block is
// idle; the block itself does not enforce this.
module min_heap_priority_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_vertex_id,
  input  logic [31:0] in_cost,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_capacity,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [15:0] out_vertex,
  output logic [31:0] out_cost,
  output logic [8:0]  out_entry_count,
  output logic        out_is_empty
);

  mhpq_pkg::ctl_t ctl;
  mhpq_pkg::sts_t sts;
  logic [8:0] capacity_r;
  logic [mhpq_pkg::CW-1:0] count;

  // capacity register, reset to full depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= 9'd256;
    end else if (cfg_we) begin
      capacity_r <= cfg_capacity;
    end
  end

  mhpq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  mhpq_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_kind      (in_kind),
    .in_vertex_id (in_vertex_id),
    .in_cost      (in_cost),
    .capacity     (capacity_r),
    .ctl          (ctl),
    .sts          (sts),
    .status       (out_status),
    .vertex       (out_vertex),
    .cost         (out_cost),
    .count        (count)
  );

  // count changes only at the start of an operation, so it is final here
  assign out_valid       = ctl.done;
  assign out_entry_count = 9'(count);
  assign out_is_empty    = (count == '0);

endmodule

/* src/mhpq_ctrl.sv */
// controller state machine for the min-heap priority queue
module mhpq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  mhpq_pkg::sts_t  sts,
  output mhpq_pkg::ctl_t  ctl
);

  mhpq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mhpq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != mhpq_pkg::S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    unique case (state_r)
      mhpq_pkg::S_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          state_nxt = mhpq_pkg::S_DONE;
        end
      end
      mhpq_pkg::S_DONE: begin
        // first cycle after load: dispatch, or finish
        unique case (sts.kind)
          mhpq_pkg::KIND_INSERT: begin
            if (sts.is_full) begin
              ctl.set_full = 1'b1;
              ctl.done = 1'b1;
              state_nxt = mhpq_pkg::S_IDLE;
            end else begin
              ctl.ins_init = 1'b1;
              state_nxt = mhpq_pkg::S_UP_RD;
            end
          end
          mhpq_pkg::KIND_EXTRACT: begin
            if (sts.is_zero) begin
              ctl.set_empty = 1'b1;
              ctl.done = 1'b1;
              state_nxt = mhpq_pkg::S_IDLE;
            end else begin
              ctl.ext_init = 1'b1;
              state_nxt = mhpq_pkg::S_DN_RD_L;
            end
          end
          mhpq_pkg::KIND_FIND: begin
            if (sts.is_zero) begin
              ctl.set_nf = 1'b1;
              ctl.done = 1'b1;
              state_nxt = mhpq_pkg::S_IDLE;
            end else begin
              ctl.find_init = 1'b1;
              state_nxt = mhpq_pkg::S_FIND_RD;
            end
          end
          default: begin
            ctl.done = 1'b1;
            state_nxt = mhpq_pkg::S_IDLE;
          end
        endcase
      end
      mhpq_pkg::S_UP_RD: begin
        if (sts.at_root) begin
          ctl.up_place = 1'b1;
          ctl.done = 1'b1;
          state_nxt = mhpq_pkg::S_IDLE;
        end else begin
          ctl.rd_parent = 1'b1;
          state_nxt = mhpq_pkg::S_UP_CMP;
        end
      end
      mhpq_pkg::S_UP_CMP: begin
        if (sts.up_less) begin
          ctl.up_move = 1'b1;
          state_nxt = mhpq_pkg::S_UP_RD;
        end else begin
          ctl.up_place = 1'b1;
          ctl.done = 1'b1;
          state_nxt = mhpq_pkg::S_IDLE;
        end
      end
      mhpq_pkg::S_DN_RD_L: begin
        if (!sts.has_left) begin
          ctl.dn_place = 1'b1;
          ctl.done = 1'b1;
          state_nxt = mhpq_pkg::S_IDLE;
        end else begin
          ctl.rd_left = 1'b1;
          state_nxt = mhpq_pkg::S_DN_RD_R;
        end
      end
      mhpq_pkg::S_DN_RD_R: begin
        ctl.latch_left = 1'b1;
        ctl.rd_right = sts.has_right;
        state_nxt = mhpq_pkg::S_DN_CMP;
      end
      mhpq_pkg::S_DN_CMP: begin
        if (sts.dn_swap) begin
          ctl.dn_move = 1'b1;
          state_nxt = mhpq_pkg::S_DN_RD_L;
        end else begin
          ctl.dn_place = 1'b1;
          ctl.done = 1'b1;
          state_nxt = mhpq_pkg::S_IDLE;
        end
      end
      mhpq_pkg::S_FIND_RD: begin
        ctl.rd_find = 1'b1;
        state_nxt = mhpq_pkg::S_FIND_CMP;
      end
      mhpq_pkg::S_FIND_CMP: begin
        if (sts.find_match) begin
          ctl.find_hit = 1'b1;
          ctl.done = 1'b1;
          state_nxt = mhpq_pkg::S_IDLE;
        end else if (sts.find_last) begin
          ctl.set_nf = 1'b1;
          ctl.done = 1'b1;
          state_nxt = mhpq_pkg::S_IDLE;
        end else begin
          ctl.find_next = 1'b1;
          state_nxt = mhpq_pkg::S_FIND_RD;
        end
      end
      default: begin
        state_nxt = mhpq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* src/mhpq_dp.sv */
// datapath of the min-heap priority queue: heap memory, position and compare
module mhpq_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [1:0]                 in_kind,
  input  logic [15:0]                in_vertex_id,
  input  logic [31:0]                in_cost,
  input  logic [8:0]                 capacity,
  input  mhpq_pkg::ctl_t             ctl,
  output mhpq_pkg::sts_t             sts,
  output logic [1:0]                 status,
  output logic [15:0]                vertex,
  output logic [31:0]                cost,
  output logic [mhpq_pkg::CW-1:0]    count
);

  localparam int unsigned AW = mhpq_pkg::AW;
  localparam int unsigned CW = mhpq_pkg::CW;

  mhpq_pkg::entry_t mem [1:mhpq_pkg::DEPTH];
  mhpq_pkg::entry_t rd_r;

  logic [1:0]            kind_r;
  logic [15:0]           vid_r;
  mhpq_pkg::entry_t      carry_r;     // entry being sifted
  mhpq_pkg::entry_t      left_r;
  logic [AW-1:0]         pos_r;
  logic [CW-1:0]         count_r;
  logic [1:0]            status_r;
  logic [15:0]           ov_r;
  logic [31:0]           oc_r;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  mhpq_pkg::entry_t      wr_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;

  logic [AW:0]           left_idx;
  logic [AW:0]           right_idx;
  logic [CW:0]           limit;
  logic                  right_valid_r;

  assign left_idx  = {pos_r, 1'b0};
  assign right_idx = {pos_r, 1'b1};
  assign limit = (capacity > 9'(mhpq_pkg::DEPTH)) ? (CW+1)'(mhpq_pkg::DEPTH)
                                                   : (CW+1)'(capacity);

  // right child compare uses the freshly read data; left is latched
  logic left_lt, right_lt;
  assign left_lt  = left_r.cost < carry_r.cost;
  assign right_lt = rd_r.cost < (left_lt ? left_r.cost : carry_r.cost);

  always_comb begin
    sts.kind       = mhpq_pkg::kind_t'(kind_r);
    sts.is_full    = {1'b0, count_r} >= limit;
    sts.is_zero    = (count_r == '0);
    sts.at_root    = (pos_r == AW'(1));
    sts.up_less    = carry_r.cost < rd_r.cost;
    sts.has_left   = left_idx <= (AW+1)'(count_r);
    sts.has_right  = right_idx <= (AW+1)'(count_r);
    sts.dn_swap    = left_lt || (right_valid_r && right_lt);
    sts.find_match = (rd_r.vertex == vid_r);
    sts.find_last  = (pos_r == AW'(count_r));
  end

  // memory port selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_r;
    wr_data = carry_r;
    rd_en   = 1'b0;
    rd_addr = pos_r;
    if (ctl.up_move) begin
      wr_en = 1'b1;
      wr_data = rd_r;
    end else if (ctl.up_place || ctl.dn_place) begin
      wr_en = 1'b1;
    end else if (ctl.dn_move) begin
      wr_en = 1'b1;
      wr_data = (right_valid_r && right_lt) ? rd_r : left_r;
    end
    if (ctl.rd_parent) begin
      rd_en = 1'b1;
      rd_addr = pos_r >> 1;
    end else if (ctl.rd_left) begin
      rd_en = 1'b1;
      rd_addr = left_idx[AW-1:0];
    end else if (ctl.rd_right) begin
      rd_en = 1'b1;
      rd_addr = right_idx[AW-1:0];
    end else if (ctl.rd_find) begin
      rd_en = 1'b1;
    end else if (ctl.load) begin
      // root fetched on every accept so an extract has it in the next cycle
      rd_en = 1'b1;
      rd_addr = AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  // extract needs the last entry as carry; read it while root is fetched
  mhpq_pkg::entry_t last_q;
  always_ff @(posedge clk) begin
    last_q <= mem[AW'(count_r)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.ins_init) begin
      count_r <= count_r + CW'(1);
    end else if (ctl.ext_init) begin
      count_r <= count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      kind_r   <= in_kind;
      vid_r    <= in_vertex_id;
      carry_r  <= '{vertex: in_vertex_id, cost: in_cost};
      status_r <= mhpq_pkg::ST_OK;
      ov_r     <= '0;
      oc_r     <= '0;
    end
    if (ctl.ins_init) begin
      pos_r <= AW'(count_r + CW'(1));
    end
    if (ctl.ext_init) begin
      pos_r   <= AW'(1);
      carry_r <= last_q;
      ov_r    <= rd_r.vertex;
      oc_r    <= rd_r.cost;
    end
    if (ctl.up_move) begin
      pos_r <= pos_r >> 1;
    end
    if (ctl.latch_left) begin
      left_r <= rd_r;
      right_valid_r <= ctl.rd_right;
    end
    if (ctl.dn_move) begin
      pos_r <= (right_valid_r && right_lt) ? right_idx[AW-1:0] : left_idx[AW-1:0];
    end
    if (ctl.find_init) begin
      pos_r <= AW'(1);
    end
    if (ctl.find_next) begin
      pos_r <= pos_r + AW'(1);
    end
    if (ctl.find_hit) begin
      ov_r <= rd_r.vertex;
      oc_r <= rd_r.cost;
    end
    if (ctl.set_full)  status_r <= mhpq_pkg::ST_FULL;
    if (ctl.set_empty) status_r <= mhpq_pkg::ST_EMPTY;
    if (ctl.set_nf)    status_r <= mhpq_pkg::ST_NOTFOUND;
  end

  // result comes from the finishing cycle's decisions
  always_comb begin
    status = status_r;
    vertex = ov_r;
    cost   = oc_r;
    if (ctl.set_full)  status = mhpq_pkg::ST_FULL;
    if (ctl.set_empty) status = mhpq_pkg::ST_EMPTY;
    if (ctl.set_nf)    status = mhpq_pkg::ST_NOTFOUND;
    if (ctl.find_hit) begin
      vertex = rd_r.vertex;
      cost   = rd_r.cost;
    end
  end

  assign count = count_r;

endmodule

/* tb/min_heap_priority_queue_test.sv */
// self-checking testbench for the min-heap priority queue
`timescale 1ns / 1ps

module min_heap_priority_queue_test;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  // one expected result of the block
  typedef struct {
    mhpq_pkg::status_t status;
    logic [15:0] vertex;
    logic [31:0] cost;
    logic [8:0]  entry_count;
    logic        is_empty;
  } heap_result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_kind;
  logic [15:0] in_vertex_id;
  logic [31:0] in_cost;
  logic        cfg_we;
  logic [8:0]  cfg_capacity;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [15:0] out_vertex;
  logic [31:0] out_cost;
  logic [8:0]  out_entry_count;
  logic        out_is_empty;

  // shadow copy of the heap kept by the predictor, slots 1..shadow_count used
  logic [15:0]  shadow_vertex [1:mhpq_pkg::DEPTH];
  logic [31:0]  shadow_cost   [1:mhpq_pkg::DEPTH];
  int unsigned  shadow_count;
  logic [8:0]   shadow_capacity;

  heap_result_t pending_results [$];
  int unsigned  mismatch_count;
  int unsigned  cycle_count;
  int unsigned  idle_pct;

  min_heap_priority_queue DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_vertex_id    (in_vertex_id),
    .in_cost         (in_cost),
    .cfg_we          (cfg_we),
    .cfg_capacity    (cfg_capacity),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_vertex      (out_vertex),
    .out_cost        (out_cost),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic swap_shadow(input int unsigned a, input int unsigned b);
    logic [15:0] tv;
    logic [31:0] tc;
    tv = shadow_vertex[a];
    tc = shadow_cost[a];
    shadow_vertex[a] = shadow_vertex[b];
    shadow_cost[a]   = shadow_cost[b];
    shadow_vertex[b] = tv;
    shadow_cost[b]   = tc;
  endtask

  // apply one operation to the shadow heap and queue the result it must give
  task automatic predict_heap_op(input mhpq_pkg::kind_t kind, input logic [15:0] vid,
                                 input logic [31:0] cst);
    heap_result_t r;
    int unsigned  limit, pos, best, i;
    r.status = mhpq_pkg::ST_OK;
    r.vertex = '0;
    r.cost   = '0;
    limit = (shadow_capacity > mhpq_pkg::DEPTH) ? mhpq_pkg::DEPTH : shadow_capacity;
    case (kind)
      mhpq_pkg::KIND_INSERT: begin
        if (shadow_count >= limit) begin
          r.status = mhpq_pkg::ST_FULL;
        end else begin
          shadow_count++;
          shadow_vertex[shadow_count] = vid;
          shadow_cost[shadow_count]   = cst;
          // sift up while strictly cheaper than the parent
          pos = shadow_count;
          while (pos > 1 && shadow_cost[pos] < shadow_cost[pos / 2]) begin
            swap_shadow(pos, pos / 2);
            pos = pos / 2;
          end
        end
      end
      mhpq_pkg::KIND_EXTRACT: begin
        if (shadow_count == 0) begin
          r.status = mhpq_pkg::ST_EMPTY;
        end else begin
          r.vertex = shadow_vertex[1];
          r.cost   = shadow_cost[1];
          shadow_vertex[1] = shadow_vertex[shadow_count];
          shadow_cost[1]   = shadow_cost[shadow_count];
          shadow_count--;
          // sift down, left child wins ties
          pos = 1;
          forever begin
            best = pos;
            if (2 * pos <= shadow_count && shadow_cost[2 * pos] < shadow_cost[best])
              best = 2 * pos;
            if (2 * pos + 1 <= shadow_count && shadow_cost[2 * pos + 1] < shadow_cost[best])
              best = 2 * pos + 1;
            if (best == pos) break;
            swap_shadow(pos, best);
            pos = best;
          end
        end
      end
      mhpq_pkg::KIND_FIND: begin
        // first match in storage order, root first
        r.status = mhpq_pkg::ST_NOTFOUND;
        for (i = 1; i <= shadow_count; i++) begin
          if (shadow_vertex[i] == vid) begin
            r.status = mhpq_pkg::ST_OK;
            r.vertex = shadow_vertex[i];
            r.cost   = shadow_cost[i];
            break;
          end
        end
      end
      default: ;  // unused kind changes nothing
    endcase
    r.entry_count = shadow_count[8:0];
    r.is_empty    = (shadow_count == 0);
    pending_results.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("error at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // results are sampled mid-cycle so nothing depends on edge ordering
  always @(negedge clk) begin
    heap_result_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing outstanding", 32'd1, 32'd0);
      end else begin
        e = pending_results.pop_front();
        if (out_status !== e.status)
          report_mismatch("status", 32'(out_status), 32'(e.status));
        if (out_vertex !== e.vertex)
          report_mismatch("vertex", 32'(out_vertex), 32'(e.vertex));
        if (out_cost !== e.cost) report_mismatch("cost", out_cost, e.cost);
        if (out_entry_count !== e.entry_count)
          report_mismatch("entry count", 32'(out_entry_count), 32'(e.entry_count));
        if (out_is_empty !== e.is_empty)
          report_mismatch("empty flag", 32'(out_is_empty), 32'(e.is_empty));
      end
    end
  end

  // one command transfer; called at a rising edge, returns at the accepting edge
  task automatic send_heap_op(input mhpq_pkg::kind_t kind, input logic [15:0] vid,
                              input logic [31:0] cst);
    int unsigned gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(6, 1) : 0;
    // start was lowered at the previous transfer edge, so step at least once
    repeat (gap + 1) @(posedge clk);
    start        <= 1'b1;
    in_kind      <= kind;
    in_vertex_id <= vid;
    in_cost      <= cst;
    do @(negedge clk); while (busy);
    @(posedge clk);
    start <= 1'b0;
    predict_heap_op(kind, vid, cst);
  endtask

  // wait until every outstanding result has come back, plus some margin
  task automatic drain_results;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [8:0] value);
    drain_results();
    cfg_we       <= 1'b1;
    cfg_capacity <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_capacity = value;
  endtask

  // random cost: mostly small so ties and equal keys happen often
  function automatic logic [31:0] pick_cost();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 55) return $urandom_range(20);
    if (sel < 60) return 32'hFFFF_FFFF;
    if (sel < 63) return 32'd0;
    return $urandom;
  endfunction

  function automatic logic [15:0] pick_vertex();
    if ($urandom_range(99) < 80) return 16'($urandom_range(31));
    return 16'($urandom);
  endfunction

  // random operation mix; fill_bias pushes toward inserts to grow the heap
  task automatic random_heap_ops(input int unsigned n, input int unsigned fill_bias);
    int unsigned sel;
    repeat (n) begin
      sel = $urandom_range(99);
      if (sel < 40 + fill_bias)
        send_heap_op(mhpq_pkg::KIND_INSERT, pick_vertex(), pick_cost());
      else if (sel < 75 + fill_bias / 2)
        send_heap_op(mhpq_pkg::KIND_EXTRACT, 16'($urandom), $urandom);
      else if (sel < 97)
        send_heap_op(mhpq_pkg::KIND_FIND, pick_vertex(), $urandom);
      else
        send_heap_op(mhpq_pkg::KIND_NONE, 16'($urandom), $urandom);
    end
  endtask

  task automatic test_empty_and_extremes;
    idle_pct = 0;
    send_heap_op(mhpq_pkg::KIND_EXTRACT, 16'hFFFF, 32'hFFFF_FFFF);  // extract from empty
    send_heap_op(mhpq_pkg::KIND_FIND, 16'd0, 32'd0);                // find on empty
    send_heap_op(mhpq_pkg::KIND_NONE, 16'hFFFF, 32'hFFFF_FFFF);
    send_heap_op(mhpq_pkg::KIND_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
    send_heap_op(mhpq_pkg::KIND_INSERT, 16'h0000, 32'h0000_0000);
    send_heap_op(mhpq_pkg::KIND_INSERT, 16'h5A5A, 32'h0000_0007);
    send_heap_op(mhpq_pkg::KIND_INSERT, 16'hA5A5, 32'h0000_0007);  // equal cost
    send_heap_op(mhpq_pkg::KIND_FIND, 16'hFFFF, 32'd0);
    send_heap_op(mhpq_pkg::KIND_FIND, 16'h1234, 32'd0);             // no match
    send_heap_op(mhpq_pkg::KIND_NONE, 16'd0, 32'd0);
    repeat (5) send_heap_op(mhpq_pkg::KIND_EXTRACT, 16'd0, 32'd0);  // last one hits empty
  endtask

  task automatic test_capacity_limits;
    write_capacity(9'd0);  // every insert full
    send_heap_op(mhpq_pkg::KIND_INSERT, 16'd1, 32'd1);
    write_capacity(9'd1);
    send_heap_op(mhpq_pkg::KIND_INSERT, 16'd2, 32'd9);
    send_heap_op(mhpq_pkg::KIND_INSERT, 16'd3, 32'd4);  // full
    write_capacity(9'd511);                             // clamps to the heap depth
    repeat (3) send_heap_op(mhpq_pkg::KIND_INSERT, pick_vertex(), pick_cost());
    write_capacity(9'd2);                               // now below the stored count
    send_heap_op(mhpq_pkg::KIND_INSERT, 16'd7, 32'd0);
    repeat (3) send_heap_op(mhpq_pkg::KIND_EXTRACT, 16'd0, 32'd0);
    send_heap_op(mhpq_pkg::KIND_INSERT, 16'd7, 32'd0);
  endtask

  // fill to the full depth once, then empty it again
  task automatic test_full_depth;
    write_capacity(9'd256);
    idle_pct = 0;
    repeat (258) send_heap_op(mhpq_pkg::KIND_INSERT, pick_vertex(), pick_cost());
    repeat (4) send_heap_op(mhpq_pkg::KIND_FIND, pick_vertex(), 32'd0);
    repeat (258) send_heap_op(mhpq_pkg::KIND_EXTRACT, 16'd0, 32'd0);
  endtask

  task automatic test_random_mix;
    write_capacity(9'd16);
    idle_pct = 0;
    random_heap_ops(80, 10);
    write_capacity(9'($urandom_range(8, 1)));
    idle_pct = 80;
    random_heap_ops(80, 0);
    // hold off until the block has answered everything
    drain_results();
    write_capacity(9'd40);
    idle_pct = 38;
    random_heap_ops(90, 15);
    write_capacity(9'd3);
    idle_pct = 80;
    random_heap_ops(40, 5);
    write_capacity(9'd400);
    idle_pct = 0;
    random_heap_ops(60, 20);
    write_capacity(9'd64);
    idle_pct = 38;
    random_heap_ops(54, 0);
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_kind         = mhpq_pkg::KIND_NONE;
    in_vertex_id    = '0;
    in_cost         = '0;
    cfg_we          = 1'b0;
    cfg_capacity    = '0;
    shadow_count    = 0;
    shadow_capacity = 9'd256;
    mismatch_count  = 0;
    cycle_count     = 0;
    idle_pct        = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_and_extremes();
    test_capacity_limits();
    test_full_depth();
    test_random_mix();

    drain_results();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
